// ----- rtl/cfa_pkg.sv -----
// Shared types and constants for the contiguous frame allocator.
// Used by cfa_ctrl, cfa_dp, the core and its checker; no dependencies.
package cfa_pkg;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;
  localparam logic [1:0] ST_NOTHEAD = 2'd3;

  typedef struct packed {
    logic        func;
    logic [15:0] size_bytes;
    logic [3:0]  free_frame;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] start_frame;
    logic [4:0] frame_count;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

endpackage

// ----- rtl/contiguous_frame_allocator_core.sv -----
// Top level of the first-fit contiguous frame allocator.
// Depends on cfa_pkg, cfa_ctrl and cfa_dp.
//
//   channel  dir  handshake              payload
//   req      in   req_valid / req_ready  cfa_pkg::req_t (func, size_bytes, free_frame)
//   rsp      out  rsp_valid / rsp_ready  cfa_pkg::rsp_t (status, start_frame, frame_count)
//
// One request at a time. Allocate scans the frame map one frame per cycle
// until a fitting run is found or the last frame has been scanned. Free and
// zero-size allocate skip the scan.
// Synchronous reset marks all frames free; no clearing pass is needed.
// A held result stalls only the commit of the next request.
module contiguous_frame_allocator_core #(
  parameter int NUM_FRAMES  = 16,
  parameter int FRAME_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cfa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cfa_pkg::rsp_t rsp
);

  cfa_pkg::cmd_t cmd;
  cfa_pkg::sts_t sts;

  cfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfa_dp #(
    .NUM_FRAMES  (NUM_FRAMES),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

// ----- rtl/cfa_ctrl.sv -----
// Controller for the frame allocator: sequences load, scan and commit.
// Depends on cfa_pkg.
module cfa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  input  cfa_pkg::sts_t sts,
  output cfa_pkg::cmd_t cmd
);

  cfa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      cfa_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = cfa_pkg::S_SCAN;
        end
      end
      cfa_pkg::S_SCAN: begin
        if (sts.done) begin
          state_next = cfa_pkg::S_WRITE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      cfa_pkg::S_WRITE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.commit = 1'b1;
          state_next = cfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cfa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/cfa_dp.sv -----
// Datapath for the frame allocator: frame map, head marks, block lengths,
// first-fit scan counters and the result register. Depends on cfa_pkg.
module cfa_dp #(
  parameter int NUM_FRAMES  = 16,
  parameter int FRAME_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  cfa_pkg::req_t req,
  input  cfa_pkg::cmd_t cmd,
  output cfa_pkg::sts_t sts,
  output cfa_pkg::rsp_t rsp
);

  localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int LW = $clog2(NUM_FRAMES + 1);
  localparam int BW = $clog2(NUM_FRAMES * FRAME_BYTES + 1);
  localparam int CW = (BW > 16) ? BW : 16;
  localparam int FW = (IW > 4) ? IW : 4;
  localparam int MW = IW + 2;

  logic [NUM_FRAMES-1:0] reserved;
  logic [NUM_FRAMES-1:0] head;
  logic [LW-1:0]         blen [NUM_FRAMES];

  cfa_pkg::req_t req_r;
  logic [IW-1:0] idx;
  logic [LW-1:0] run;
  logic [BW-1:0] rbytes;
  logic          found;
  logic          done;
  logic [IW-1:0] first;
  logic [LW-1:0] need;

  logic [LW-1:0] run_next;
  logic [BW-1:0] rbytes_next;
  logic          hit;
  logic [IW:0]   end_pos;
  logic [IW:0]   first_full;

  logic [FW-1:0]         fr;
  logic                  in_range;
  logic [IW-1:0]         fidx;
  logic                  head_ok;
  logic [LW-1:0]         flen;
  logic [NUM_FRAMES-1:0] amask;
  logic [NUM_FRAMES-1:0] fmask;
  logic                  is_free;
  cfa_pkg::rsp_t         result;

  // scan step
  always_comb begin
    if (reserved[idx]) begin
      run_next    = '0;
      rbytes_next = '0;
    end else begin
      run_next    = run + LW'(1);
      rbytes_next = rbytes + BW'(FRAME_BYTES);
    end
    hit        = (CW'(rbytes_next) >= CW'(req_r.size_bytes));
    end_pos    = {1'b0, idx} + (IW+1)'(1);
    first_full = end_pos - (IW+1)'(run_next);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= req;
      idx    <= '0;
      run    <= '0;
      rbytes <= '0;
      found  <= 1'b0;
      done   <= (req.func == cfa_pkg::FUNC_FREE) || (req.size_bytes == 16'd0);
    end else if (cmd.step) begin
      run    <= run_next;
      rbytes <= rbytes_next;
      if (hit) begin
        found <= 1'b1;
        done  <= 1'b1;
        first <= first_full[IW-1:0];
        need  <= run_next;
      end else if (idx == IW'(NUM_FRAMES - 1)) begin
        done <= 1'b1;
      end else begin
        idx <= idx + IW'(1);
      end
    end
  end

  assign sts.done = done;

  // result and commit
  always_comb begin
    is_free  = (req_r.func == cfa_pkg::FUNC_FREE);
    fr       = FW'(req_r.free_frame);
    in_range = ({1'b0, fr} < (FW+1)'(NUM_FRAMES));
    fidx     = IW'(fr);
    head_ok  = in_range && head[fidx];
    flen     = blen[fidx];
    for (int i = 0; i < NUM_FRAMES; i++) begin
      amask[i] = (MW'(i) >= MW'(first)) && (MW'(i) < (MW'(first) + MW'(need)));
      fmask[i] = (MW'(i) >= MW'(fidx)) && (MW'(i) < (MW'(fidx) + MW'(flen)));
    end
    result = '0;
    if (is_free) begin
      if (head_ok) begin
        result.status      = cfa_pkg::ST_FREED;
        result.start_frame = req_r.free_frame;
        result.frame_count = 5'(flen);
      end else begin
        result.status = cfa_pkg::ST_NOTHEAD;
      end
    end else if (found) begin
      result.status      = cfa_pkg::ST_ALLOC;
      result.start_frame = 4'(first);
      result.frame_count = 5'(need);
    end else begin
      result.status = cfa_pkg::ST_NOSPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
      head     <= '0;
    end else if (cmd.commit) begin
      if (is_free && head_ok) begin
        reserved <= reserved & ~fmask;
        head     <= head & ~fmask;
      end else if (!is_free && found) begin
        reserved    <= reserved | amask;
        head[first] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !is_free && found) begin
      blen[first] <= need;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= result;
    end
  end

endmodule

// ----- rtl/cfa_checker.sv -----
// Port-level checks for contiguous_frame_allocator_core, bound to the top.
// Depends on cfa_pkg.
module cfa_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input cfa_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input cfa_pkg::rsp_t rsp
);

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while stalled");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == cfa_pkg::ST_NOSPACE || rsp.status == cfa_pkg::ST_NOTHEAD)
    |-> rsp.start_frame == 4'd0 && rsp.frame_count == 5'd0)
    else $error("failed request reports frames");

  a_alloc_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == cfa_pkg::ST_ALLOC |-> rsp.frame_count != 5'd0)
    else $error("allocation of zero frames");

endmodule

bind contiguous_frame_allocator_core cfa_checker u_cfa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ----- dv/contiguous_frame_allocator_core_tb.sv -----
// Self-checking testbench for contiguous_frame_allocator_core: predicts first-fit alloc/free
// results from a frame map kept in a scoreboard class. Depends on cfa_pkg and the core RTL.
`timescale 1ns / 1ps

module contiguous_frame_allocator_core_tb;

  localparam int NUM_FRAMES  = 16;
  localparam int FRAME_BYTES = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 360;

  class frame_ledger;
    bit            taken[NUM_FRAMES];
    bit            is_head[NUM_FRAMES];
    bit [4:0]      run_len[NUM_FRAMES];
    cfa_pkg::rsp_t due_responses[$];
    int            errors;

    function void predict_request(cfa_pkg::req_t r);
      cfa_pkg::rsp_t e;
      int need, run, i, first, k, len;
      e = '0;
      if (r.func == cfa_pkg::FUNC_ALLOC) begin
        need = (int'(r.size_bytes) + FRAME_BYTES - 1) / FRAME_BYTES;
        e.status = cfa_pkg::ST_NOSPACE;
        if (need != 0 && need <= NUM_FRAMES) begin
          run = 0;
          i = 0;
          while (i < NUM_FRAMES && run < need) begin
            run = taken[i] ? 0 : run + 1;
            i++;
          end
          if (run == need) begin
            first = i - need;
            for (k = first; k < first + need; k++) begin
              taken[k]   = 1'b1;
              is_head[k] = (k == first);
              run_len[k] = need[4:0];
            end
            e.status      = cfa_pkg::ST_ALLOC;
            e.start_frame = first[3:0];
            e.frame_count = need[4:0];
          end
        end
      end else if (int'(r.free_frame) < NUM_FRAMES && is_head[r.free_frame]) begin
        first = int'(r.free_frame);
        len = int'(run_len[first]);
        for (k = first; k < first + len && k < NUM_FRAMES; k++) begin
          taken[k]   = 1'b0;
          is_head[k] = 1'b0;
          run_len[k] = '0;
        end
        e.status      = cfa_pkg::ST_FREED;
        e.start_frame = r.free_frame;
        e.frame_count = len[4:0];
      end else begin
        e.status = cfa_pkg::ST_NOTHEAD;
      end
      due_responses.push_back(e);
    endfunction

    function void check_response(cfa_pkg::rsp_t got);
      cfa_pkg::rsp_t e;
      if (due_responses.size() == 0) begin
        $display("%0t: unexpected transfer status %0d start %0d count %0d",
                 $time, got.status, got.start_frame, got.frame_count);
        errors++;
        return;
      end
      e = due_responses.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.start_frame !== e.start_frame) begin
        $display("%0t: start_frame expected %0d got %0d", $time, e.start_frame,
                 got.start_frame);
        errors++;
      end
      if (got.frame_count !== e.frame_count) begin
        $display("%0t: frame_count expected %0d got %0d", $time, e.frame_count,
                 got.frame_count);
        errors++;
      end
    endfunction

    function int live_head();
      int heads[$];
      int k;
      for (k = 0; k < NUM_FRAMES; k++) begin
        if (is_head[k]) heads.push_back(k);
      end
      if (heads.size() == 0) return -1;
      return heads[$urandom_range(heads.size() - 1)];
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  cfa_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  cfa_pkg::rsp_t rsp;

  int tx_idle_pct;
  int rx_idle_pct;
  int stall_cycles = 0;
  frame_ledger ledger = new();

  contiguous_frame_allocator_core #(
    .NUM_FRAMES(NUM_FRAMES),
    .FRAME_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) ledger.check_response(rsp);
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic cfa_pkg::req_t alloc_req(int bytes);
    cfa_pkg::req_t r;
    r.func       = cfa_pkg::FUNC_ALLOC;
    r.size_bytes = bytes[15:0];
    r.free_frame = 4'($urandom);
    return r;
  endfunction

  function automatic cfa_pkg::req_t free_req(int frame);
    cfa_pkg::req_t r;
    r.func       = cfa_pkg::FUNC_FREE;
    r.size_bytes = 16'($urandom);
    r.free_frame = frame[3:0];
    return r;
  endfunction

  task automatic send_request(input cfa_pkg::req_t r);
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    ledger.predict_request(r);
    if ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_random_request();
    int pick, frames, h;
    cfa_pkg::req_t r;
    pick = $urandom_range(99);
    if (pick < 45) begin
      frames = ($urandom_range(4) == 0) ? $urandom_range(5, NUM_FRAMES) : $urandom_range(1, 4);
      send_request(alloc_req((frames - 1) * FRAME_BYTES + $urandom_range(1, FRAME_BYTES)));
    end else if (pick < 85) begin
      h = ledger.live_head();
      send_request(free_req(h < 0 ? $urandom_range(NUM_FRAMES - 1) : h));
    end else if (pick < 89) begin
      send_request(alloc_req(0));
    end else begin
      r = cfa_pkg::req_t'($bits(cfa_pkg::req_t)'($urandom));
      send_request(r);
    end
  endtask

  initial begin
    tx_idle_pct = 17;
    rx_idle_pct = 83;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // zero size, oversize, full region, frees of heads, interiors and stale heads
    send_request(alloc_req(0));
    send_request(alloc_req(65535));
    send_request(alloc_req(NUM_FRAMES * FRAME_BYTES + 1));
    send_request(alloc_req(NUM_FRAMES * FRAME_BYTES));
    send_request(alloc_req(1));
    send_request(free_req(5));
    send_request(free_req(0));
    send_request(free_req(0));
    send_request(alloc_req(1));
    send_request(alloc_req(FRAME_BYTES + 1));
    send_request(alloc_req(FRAME_BYTES));
    send_request(alloc_req(2 * FRAME_BYTES));
    send_request(free_req(1));
    send_request(free_req(2));
    send_request(alloc_req(2 * FRAME_BYTES + 1));
    send_request(alloc_req(40));
    send_request(free_req(15));
    send_request(free_req(0));
    send_request(free_req(3));
    send_request(free_req(4));
    send_request(free_req(6));
    send_request(free_req(1));

    repeat (RANDOM_PER_PHASE) send_random_request();
    tx_idle_pct = 83;
    rx_idle_pct = 17;
    repeat (RANDOM_PER_PHASE) send_random_request();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (RANDOM_PER_PHASE) send_random_request();
    req_valid <= 1'b0;

    while (ledger.due_responses.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cfa_pkg.sv
rtl/cfa_ctrl.sv
rtl/cfa_dp.sv
rtl/contiguous_frame_allocator_core.sv
rtl/cfa_checker.sv
dv/contiguous_frame_allocator_core_tb.sv
